>>> design/frt_pkg.sv
`default_nettype none

package frt_pkg;

	localparam int unsigned MaxPacketLen = 244;

	localparam logic [7:0] ChQuestion = 8'h3F;
	localparam logic [7:0] ChHash     = 8'h23;

	localparam logic [7:0] StopB0 = 8'h5A;
	localparam logic [7:0] StopB1 = 8'hA5;
	localparam logic [7:0] StopB2 = 8'h07;
	localparam logic [7:0] StopB3 = 8'h01;
	localparam logic [7:0] StopB4 = 8'h03;

	localparam logic [7:0] HdrMinLen   = 8'd9;
	localparam logic [7:0] HdrOverhead = 8'd8;

	localparam logic [1:0] PhCodeIdle = 2'd0;
	localparam logic [1:0] PhCodeRecv = 2'd1;
	localparam logic [1:0] PhCodeWait = 2'd2;

	localparam int unsigned InDataW  = 80;
	localparam int unsigned OutDataW = 16;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_RECV = 3'b010,
		PH_WAIT = 3'b100
	} phase_t;

	typedef struct packed {
		logic        action;
		logic [7:0]  packet_length;
		logic [7:0]  header_byte0;
		logic [7:0]  header_byte1;
		logic [7:0]  header_byte2;
		logic [7:0]  header_byte3;
		logic [7:0]  header_byte4;
		logic [31:0] declared_length;
	} item_t;

	typedef struct packed {
		logic       forward;
		logic [7:0] forward_length;
		logic       advertising_off;
		logic [1:0] phase;
	} result_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] c;
		unique case (ph)
			PH_IDLE: c = PhCodeIdle;
			PH_RECV: c = PhCodeRecv;
			default: c = PhCodeWait;
		endcase
		return c;
	endfunction

	// ceil(r/63) for r up to the packet size limit (quotient at most 4)
	function automatic logic [2:0] ceil_div63(input logic [8:0] r);
		logic [9:0] x;
		logic [2:0] q;
		x = {1'b0, r} + 10'd62;
		q = 3'(x >= 10'd63) + 3'(x >= 10'd126) + 3'(x >= 10'd189) + 3'(x >= 10'd252);
		return q;
	endfunction

endpackage

`default_nettype wire

>>> design/frt_step.sv
`default_nettype none

module frt_step import frt_pkg::*; #(
	parameter int unsigned MAX_PACKET_LEN = MaxPacketLen
) (
	input  phase_t      cur_phase,
	input  logic [31:0] cur_remain,
	input  item_t       item,
	output phase_t      nxt_phase,
	output logic [31:0] nxt_remain,
	output result_t     res
);

	localparam logic [7:0] MaxLen = 8'(MAX_PACKET_LEN);

	logic [7:0] len_sat;
	logic [8:0] len_round;
	logic [7:0] ceil64;
	logic [7:0] hdr_pay;
	logic [7:0] cont_pay;
	logic       is_hdr;
	logic       is_stop;
	logic [7:0] final_len;

	always_comb begin
		len_sat   = (item.packet_length > MaxLen) ? MaxLen : item.packet_length;
		len_round = {1'b0, len_sat} + 9'd63;
		ceil64    = {5'd0, len_round[8:6]};
		hdr_pay   = len_sat - ceil64 - HdrOverhead;
		cont_pay  = len_sat - ceil64;
		is_hdr    = item.header_byte0 == ChQuestion && item.header_byte1 == ChHash &&
			item.header_byte2 == ChHash;
		is_stop   = item.header_byte0 == StopB0 && item.header_byte1 == StopB1 &&
			item.header_byte2 == StopB2 && item.header_byte3 == StopB3 &&
			item.header_byte4 == StopB4;
		// closing packet: remaining count is below the packet size here
		final_len = cur_remain[7:0] + {5'd0, ceil_div63(cur_remain[8:0])};

		nxt_phase  = cur_phase;
		nxt_remain = cur_remain;
		res.forward         = 1'b0;
		res.forward_length  = 8'd0;
		res.advertising_off = 1'b0;

		if (item.action) begin
			unique case (cur_phase)
				PH_IDLE: nxt_phase = PH_IDLE;
				PH_RECV: nxt_phase = PH_WAIT;
				default: nxt_phase = PH_IDLE;
			endcase
		end else if (cur_phase == PH_IDLE) begin
			if (is_hdr) begin
				if (len_sat >= HdrMinLen) begin
					nxt_remain = item.declared_length;
					if (item.declared_length > {24'd0, hdr_pay}) begin
						nxt_remain = item.declared_length - {24'd0, hdr_pay};
						nxt_phase  = PH_RECV;
					end
					res.forward        = 1'b1;
					res.forward_length = len_sat;
				end
			end else if (is_stop) begin
				res.advertising_off = 1'b1;
			end else begin
				res.forward        = 1'b1;
				res.forward_length = len_sat;
			end
		end else begin
			res.forward = 1'b1;
			res.forward_length = len_sat;
			if (item.header_byte0 == ChQuestion) begin
				if ({24'd0, cont_pay} >= cur_remain) begin
					nxt_phase          = PH_IDLE;
					nxt_remain         = 32'd0;
					res.forward_length = final_len;
				end else begin
					nxt_remain = cur_remain - {24'd0, cont_pay};
					nxt_phase  = PH_RECV;
				end
			end else begin
				nxt_phase = PH_IDLE;
			end
		end

		res.phase = phase_code(nxt_phase);
	end

endmodule

`default_nettype wire

>>> design/frame_reassembly_tracker_top.sv
`default_nettype none

// frame reassembly tracker: follows multi-packet messages from a radio link.
// every input beat is a received packet header (s_tuser = 0) or a timeout tick
// (s_tuser = 1), and every input beat gives exactly one output beat, in order.
// an idle '?##' header of 9 bytes or more announces a message length and moves
// the tracker to receiving while bytes are still owed; '?' packets continue it,
// the closing one forwarded as remain + ceil(remain/63) bytes; ticks step
// receiving to waiting and waiting to idle. in idle the stop-advertising
// command is flagged and not forwarded. timing: a beat is registered on
// entry and its result is computed from that register straight into the
// output register; one beat is taken every cycle unless the output is held
// by m_tready; the tracker state (phase and remaining byte count) updates
// as the output register loads, which is the single loop that bounds the
// rate. packet lengths above MAX_PACKET_LEN are clamped before use.
module frame_reassembly_tracker_top import frt_pkg::*; #(
	parameter int unsigned MAX_PACKET_LEN = MaxPacketLen
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	// packet_length[7:0], header_byte0..4 [47:8], declared_length[79:48]
	input  wire  [InDataW-1:0]  s_tdata,
	// action[0]
	input  wire                 s_tuser,
	output logic                m_tvalid,
	input  wire                 m_tready,
	// forward[0], forward_length[8:1], advertising_off[9], phase[11:10], zero[15:12]
	output logic [OutDataW-1:0] m_tdata
);

	// input stage
	item_t       item_s1;
	logic        valid_s1;

	// tracker state
	phase_t      state_q;
	logic [31:0] remain_q;

	// result register
	result_t     result_q;
	logic        out_valid_q;

	phase_t      nxt_phase;
	logic [31:0] nxt_remain;
	result_t     nxt_res;
	logic        advance;
	logic        in_beat;

	// a staged beat moves on when the output slot is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_beat  = s_tvalid && s_tready;

	frt_step #(
		.MAX_PACKET_LEN(MAX_PACKET_LEN)
	) u_step (
		.cur_phase (state_q),
		.cur_remain(remain_q),
		.item      (item_s1),
		.nxt_phase (nxt_phase),
		.nxt_remain(nxt_remain),
		.res       (nxt_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= PH_IDLE;
			remain_q    <= 32'd0;
		end else begin
			if (in_beat) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= nxt_phase;
				remain_q    <= nxt_remain;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			item_s1.action          <= s_tuser;
			item_s1.packet_length   <= s_tdata[7:0];
			item_s1.header_byte0    <= s_tdata[15:8];
			item_s1.header_byte1    <= s_tdata[23:16];
			item_s1.header_byte2    <= s_tdata[31:24];
			item_s1.header_byte3    <= s_tdata[39:32];
			item_s1.header_byte4    <= s_tdata[47:40];
			item_s1.declared_length <= s_tdata[79:48];
		end
		if (advance) begin
			result_q <= nxt_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, result_q.phase, result_q.advertising_off,
		result_q.forward_length, result_q.forward};

	// the phase reported with a result is the phase the tracker holds after it
	a_phase_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> result_q.phase == phase_code(state_q))
		else $error("result phase differs from tracker state");

	// nothing forwarded means a zero length
	a_len_zero_no_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_q.forward |-> result_q.forward_length == 8'd0)
		else $error("length reported on a beat that is not forwarded");

	// the stop command is only seen in idle and is never forwarded
	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.advertising_off |->
			!result_q.forward && result_q.phase == PhCodeIdle)
		else $error("advertising-off with forward or outside idle");

	// a tracker left waiting by a tick falls back to idle on the next tick
	a_wait_tick: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.action && state_q == PH_WAIT |=> state_q == PH_IDLE)
		else $error("tick in waiting did not return to idle");

endmodule

`default_nettype wire
